>>> rtl/btff_pkg.sv
// Shared types, widths and microcode field codes for the boundary-tag allocator.
package btff_pkg;

    // Field widths fixed by the request and response transactions
    localparam int REQ_BYTES_W    = 14;
    localparam int INDEX_W        = 12;
    localparam int NEED_W         = 13;
    localparam int HEAP_WORDS_DEF = 4096;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Response status codes
    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_NOFIT = 1'b1;

    // Microprogram steps
    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP,
        S_AL0, S_AL1, S_AL2, S_AF0, S_AF1, S_AF2, S_AF3,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F5B, S_F6, S_F7, S_F8, S_F9, S_F10,
        S_ROK, S_RFAIL, S_RFREE
    } step_t;

    // Branch conditions
    typedef enum logic [3:0] {
        C_ALWAYS, C_IN_VALID, C_IS_FREE, C_SCAN_STOP, C_FIT, C_SPLIT, C_IDX_OK,
        C_FREE_OK, C_NEXT_IN, C_MERGE, C_HAS_PREV, C_PREV_OK, C_OUT_FREE, C_CLR_LAST
    } cond_t;

    // Tag store read address select
    typedef enum logic [2:0] {
        RA_ZERO, RA_P_ADV, RA_IDX, RA_BASE_SZ, RA_BASE_M1, RA_BASE_BACK
    } ra_t;

    // Tag store write address select
    typedef enum logic [2:0] {
        WA_CLR, WA_BASE, WA_BASE_NEED_M1, WA_BASE_NEED, WA_BASE_SZ_M1
    } wa_t;

    // Size field of the written tag
    typedef enum logic [2:0] {
        WS_INIT, WS_NEED, WS_REM, WS_SZ, WS_TOT
    } ws_t;

    typedef enum logic [1:0] { PS_HOLD, PS_ZERO, PS_ADV } p_src_t;
    typedef enum logic [1:0] { BS_HOLD, BS_P, BS_IDX, BS_BACK } base_src_t;
    typedef enum logic [1:0] { SS_HOLD, SS_DATA, SS_TOT } sz_src_t;
    typedef enum logic [1:0] { RS_NONE, RS_OK, RS_FAIL, RS_FREE } res_t;

    // One control word of the microprogram
    typedef struct packed {
        cond_t     cond;
        step_t     jt;
        step_t     jf;
        logic      in_rdy;
        ra_t       ra;
        logic      we;
        wa_t       wa;
        ws_t       ws;
        logic      wu;
        p_src_t    p_src;
        base_src_t base_src;
        sz_src_t   sz_src;
        logic      ld_used;
        logic      ld_tot;
        res_t      res;
        logic      clr_inc;
    } ctl_t;

    // Condition flags returned by the datapath
    typedef struct packed {
        logic in_valid;
        logic is_free;
        logic scan_stop;
        logic fit;
        logic split;
        logic idx_ok;
        logic free_ok;
        logic next_in;
        logic merge;
        logic has_prev;
        logic prev_ok;
        logic out_free;
        logic clr_last;
    } flags_t;

endpackage

>>> rtl/btff_if.sv
// Request and response channel interfaces of the boundary-tag allocator.
interface btff_req_if;
    import btff_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [REQ_BYTES_W-1:0] request_bytes;
    logic [INDEX_W-1:0]     block_index;

    modport source (output valid, req_type, request_bytes, block_index, input ready);
    modport sink   (input valid, req_type, request_bytes, block_index, output ready);
endinterface

interface btff_rsp_if;
    import btff_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic [INDEX_W-1:0] granted_index;

    modport source (output valid, status, granted_index, input ready);
    modport sink   (input valid, status, granted_index, output ready);
endinterface

>>> rtl/btff_useq.sv
// Microprogram sequencer: step counter, control store and conditional branching.
module btff_useq (
    input  logic            clk,
    input  logic            rst_n,
    input  btff_pkg::flags_t flags,
    output btff_pkg::ctl_t   ctl
);
    import btff_pkg::*;

    // Control store: one word per step
    function automatic ctl_t ucode(input step_t s);
        ctl_t w;
        w          = '0;
        w.cond     = C_ALWAYS;
        w.jt       = S_IDLE;
        w.jf       = S_IDLE;
        w.ra       = RA_ZERO;
        w.wa       = WA_BASE;
        w.ws       = WS_SZ;
        w.p_src    = PS_HOLD;
        w.base_src = BS_HOLD;
        w.sz_src   = SS_HOLD;
        w.res      = RS_NONE;
        case (s)
            S_CLR:
            begin
                w.we = 1'b1; w.wa = WA_CLR; w.ws = WS_INIT; w.clr_inc = 1'b1;
                w.cond = C_CLR_LAST; w.jt = S_IDLE; w.jf = S_CLR;
            end
            S_IDLE:
            begin
                w.in_rdy = 1'b1; w.cond = C_IN_VALID; w.jt = S_DISP; w.jf = S_IDLE;
            end
            S_DISP:
            begin
                w.cond = C_IS_FREE; w.jt = S_F0; w.jf = S_AL0;
            end
            S_AL0:
            begin
                w.p_src = PS_ZERO; w.ra = RA_ZERO; w.jt = S_AL1; w.jf = S_AL1;
            end
            S_AL1:
            begin
                w.base_src = BS_P; w.p_src = PS_ADV; w.sz_src = SS_DATA; w.ld_used = 1'b1;
                w.ra = RA_P_ADV; w.cond = C_SCAN_STOP; w.jt = S_AL2; w.jf = S_AL1;
            end
            S_AL2:
            begin
                w.cond = C_FIT; w.jt = S_AF0; w.jf = S_RFAIL;
            end
            S_AF0:
            begin
                w.we = 1'b1; w.wa = WA_BASE; w.ws = WS_NEED; w.wu = 1'b1;
                w.jt = S_AF1; w.jf = S_AF1;
            end
            S_AF1:
            begin
                w.we = 1'b1; w.wa = WA_BASE_NEED_M1; w.ws = WS_NEED; w.wu = 1'b1;
                w.cond = C_SPLIT; w.jt = S_AF2; w.jf = S_ROK;
            end
            S_AF2:
            begin
                w.we = 1'b1; w.wa = WA_BASE_NEED; w.ws = WS_REM;
                w.jt = S_AF3; w.jf = S_AF3;
            end
            S_AF3:
            begin
                w.we = 1'b1; w.wa = WA_BASE_SZ_M1; w.ws = WS_REM;
                w.jt = S_ROK; w.jf = S_ROK;
            end
            S_F0:
            begin
                w.base_src = BS_IDX; w.ra = RA_IDX;
                w.cond = C_IDX_OK; w.jt = S_F1; w.jf = S_RFREE;
            end
            S_F1:
            begin
                w.sz_src = SS_DATA; w.cond = C_FREE_OK; w.jt = S_F2; w.jf = S_RFREE;
            end
            S_F2:
            begin
                w.we = 1'b1; w.wa = WA_BASE; w.ws = WS_SZ; w.jt = S_F3; w.jf = S_F3;
            end
            S_F3:
            begin
                w.we = 1'b1; w.wa = WA_BASE_SZ_M1; w.ws = WS_SZ; w.ra = RA_BASE_SZ;
                w.cond = C_NEXT_IN; w.jt = S_F4; w.jf = S_F6;
            end
            S_F4:
            begin
                w.ld_tot = 1'b1; w.cond = C_MERGE; w.jt = S_F5; w.jf = S_F6;
            end
            S_F5:
            begin
                w.we = 1'b1; w.wa = WA_BASE; w.ws = WS_TOT; w.sz_src = SS_TOT;
                w.jt = S_F5B; w.jf = S_F5B;
            end
            S_F5B:
            begin
                w.we = 1'b1; w.wa = WA_BASE_SZ_M1; w.ws = WS_SZ; w.jt = S_F6; w.jf = S_F6;
            end
            S_F6:
            begin
                w.ra = RA_BASE_M1; w.cond = C_HAS_PREV; w.jt = S_F7; w.jf = S_RFREE;
            end
            S_F7:
            begin
                w.base_src = BS_BACK; w.ra = RA_BASE_BACK;
                w.cond = C_PREV_OK; w.jt = S_F8; w.jf = S_RFREE;
            end
            S_F8:
            begin
                w.ld_tot = 1'b1; w.cond = C_MERGE; w.jt = S_F9; w.jf = S_RFREE;
            end
            S_F9:
            begin
                w.we = 1'b1; w.wa = WA_BASE; w.ws = WS_TOT; w.sz_src = SS_TOT;
                w.jt = S_F10; w.jf = S_F10;
            end
            S_F10:
            begin
                w.we = 1'b1; w.wa = WA_BASE_SZ_M1; w.ws = WS_SZ;
                w.jt = S_RFREE; w.jf = S_RFREE;
            end
            S_ROK:
            begin
                w.res = RS_OK; w.cond = C_OUT_FREE; w.jt = S_IDLE; w.jf = S_ROK;
            end
            S_RFAIL:
            begin
                w.res = RS_FAIL; w.cond = C_OUT_FREE; w.jt = S_IDLE; w.jf = S_RFAIL;
            end
            S_RFREE:
            begin
                w.res = RS_FREE; w.cond = C_OUT_FREE; w.jt = S_IDLE; w.jf = S_RFREE;
            end
            default:
            begin
                w.jt = S_IDLE; w.jf = S_IDLE;
            end
        endcase
        return w;
    endfunction

    step_t upc_reg;
    step_t upc_next;
    logic  cond_true;

    assign ctl = ucode(upc_reg);

    // Condition select
    always_comb
    begin
        case (ctl.cond)
            C_ALWAYS:    cond_true = 1'b1;
            C_IN_VALID:  cond_true = flags.in_valid;
            C_IS_FREE:   cond_true = flags.is_free;
            C_SCAN_STOP: cond_true = flags.scan_stop;
            C_FIT:       cond_true = flags.fit;
            C_SPLIT:     cond_true = flags.split;
            C_IDX_OK:    cond_true = flags.idx_ok;
            C_FREE_OK:   cond_true = flags.free_ok;
            C_NEXT_IN:   cond_true = flags.next_in;
            C_MERGE:     cond_true = flags.merge;
            C_HAS_PREV:  cond_true = flags.has_prev;
            C_PREV_OK:   cond_true = flags.prev_ok;
            C_OUT_FREE:  cond_true = flags.out_free;
            C_CLR_LAST:  cond_true = flags.clr_last;
            default:     cond_true = 1'b1;
        endcase
        upc_next = cond_true ? ctl.jt : ctl.jf;
    end

    // Step counter; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_CLR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> rtl/btff_dpath.sv
// Allocator datapath: tag store, address and size registers, flags and result register.
module btff_dpath #(
    parameter int HEAP_WORDS = btff_pkg::HEAP_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  btff_pkg::ctl_t   ctl,
    output btff_pkg::flags_t flags,
    btff_req_if.sink         req,
    btff_rsp_if.source       rsp
);
    import btff_pkg::*;

    localparam int AW  = $clog2(HEAP_WORDS);
    localparam int W   = $clog2(HEAP_WORDS + 1);
    localparam int TW  = W + 1;
    localparam int MW1 = (W > NEED_W) ? W : NEED_W;
    localparam int MW2 = (MW1 > INDEX_W) ? MW1 : INDEX_W;
    localparam int CW  = MW2 + 1;
    localparam logic [CW-1:0] HEAP_C = CW'(HEAP_WORDS);
    localparam logic [AW-1:0] LAST_A = AW'(HEAP_WORDS - 1);

    // Tag store
    logic [TW-1:0] mem [HEAP_WORDS];
    logic [TW-1:0] rdata_reg;

    // Working registers
    logic [W-1:0]       p_reg, p_next;
    logic [W-1:0]       base_reg, base_next;
    logic [W-1:0]       sz_reg, sz_next;
    logic               used_reg, used_next;
    logic [W-1:0]       tot_reg, tot_next;
    logic [NEED_W-1:0]  need_reg, need_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic               rtype_reg, rtype_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;
    logic               status_reg, status_next;
    logic [INDEX_W-1:0] granted_reg, granted_next;

    logic                 accept;
    logic [REQ_BYTES_W:0] bytes_p3;
    logic [W-1:0]         d_size;
    logic                 d_used;
    logic [CW-1:0]        p_adv, base_sz, sum;
    logic [AW-1:0]        ra, wa;
    logic [W-1:0]         wsize;
    logic [TW-1:0]        wd;
    logic                 bad_p, bad_base_sz, bad_base_d;
    logic                 out_load;

    assign d_size  = rdata_reg[TW-1:1];
    assign d_used  = rdata_reg[0];
    assign p_adv   = CW'(p_reg) + CW'(d_size);
    assign base_sz = CW'(base_reg) + CW'(sz_reg);
    assign sum     = CW'(sz_reg) + CW'(d_size);

    // A block tag is malformed if its size is zero or it runs past the heap end
    assign bad_p       = (d_size == '0) || (CW'(d_size) > HEAP_C - CW'(p_reg));
    assign bad_base_sz = (sz_reg == '0) || (CW'(sz_reg) > HEAP_C - CW'(base_reg));
    assign bad_base_d  = (d_size == '0) || (CW'(d_size) > HEAP_C - CW'(base_reg));

    // Condition flags for the sequencer
    always_comb
    begin
        flags.in_valid  = req.valid;
        flags.is_free   = (rtype_reg == REQ_FREE);
        flags.scan_stop = bad_p || (!d_used && (CW'(d_size) >= CW'(need_reg)))
                          || (p_adv >= HEAP_C);
        flags.fit       = !bad_base_sz && !used_reg && (CW'(sz_reg) >= CW'(need_reg));
        flags.split     = CW'(need_reg) < CW'(sz_reg);
        flags.idx_ok    = CW'(idx_reg) < HEAP_C;
        flags.free_ok   = !bad_base_d;
        flags.next_in   = base_sz < HEAP_C;
        flags.merge     = !d_used && (sum != '0) && (sum <= HEAP_C - CW'(base_reg));
        flags.has_prev  = (base_reg != '0);
        flags.prev_ok   = (d_size != '0) && (CW'(d_size) <= CW'(base_reg));
        flags.out_free  = !out_valid_reg || rsp.ready;
        flags.clr_last  = (clr_reg == LAST_A);
    end

    // Read and write address selection
    always_comb
    begin
        case (ctl.ra)
            RA_ZERO:      ra = '0;
            RA_P_ADV:     ra = AW'(p_adv);
            RA_IDX:       ra = AW'(idx_reg);
            RA_BASE_SZ:   ra = AW'(base_sz);
            RA_BASE_M1:   ra = AW'(CW'(base_reg) - CW'(1));
            RA_BASE_BACK: ra = AW'(CW'(base_reg) - CW'(d_size));
            default:      ra = '0;
        endcase
        case (ctl.wa)
            WA_CLR:          wa = clr_reg;
            WA_BASE:         wa = AW'(base_reg);
            WA_BASE_NEED_M1: wa = AW'(CW'(base_reg) + CW'(need_reg) - CW'(1));
            WA_BASE_NEED:    wa = AW'(CW'(base_reg) + CW'(need_reg));
            WA_BASE_SZ_M1:   wa = AW'(base_sz - CW'(1));
            default:         wa = AW'(base_reg);
        endcase
    end

    // Tag word to write: size and used bit, or the reset image during clearing
    always_comb
    begin
        case (ctl.ws)
            WS_NEED: wsize = W'(need_reg);
            WS_REM:  wsize = W'(CW'(sz_reg) - CW'(need_reg));
            WS_SZ:   wsize = sz_reg;
            WS_TOT:  wsize = tot_reg;
            default: wsize = '0;
        endcase
        if (ctl.ws == WS_INIT)
        begin
            wd = ((clr_reg == '0) || (clr_reg == LAST_A)) ? {W'(HEAP_WORDS), 1'b0} : '0;
        end
        else
        begin
            wd = {wsize, ctl.wu};
        end
    end

    // Tag store port: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[ra];
    end

    // Next values of the working registers
    assign accept   = req.valid && ctl.in_rdy;
    assign bytes_p3 = {1'b0, req.request_bytes} + (REQ_BYTES_W + 1)'(3);

    always_comb
    begin
        rtype_next = accept ? req.req_type : rtype_reg;
        idx_next   = accept ? req.block_index : idx_reg;
        need_next  = accept ? (NEED_W'(bytes_p3 >> 2) + NEED_W'(2)) : need_reg;

        case (ctl.p_src)
            PS_ZERO: p_next = '0;
            PS_ADV:  p_next = W'(p_adv);
            default: p_next = p_reg;
        endcase
        case (ctl.base_src)
            BS_P:    base_next = p_reg;
            BS_IDX:  base_next = W'(idx_reg);
            BS_BACK: base_next = base_reg - d_size;
            default: base_next = base_reg;
        endcase
        case (ctl.sz_src)
            SS_DATA: sz_next = d_size;
            SS_TOT:  sz_next = tot_reg;
            default: sz_next = sz_reg;
        endcase
        used_next = ctl.ld_used ? d_used : used_reg;
        tot_next  = ctl.ld_tot ? W'(sum) : tot_reg;
    end

    // Result register: loaded when a result step finds it free
    always_comb
    begin
        out_load       = (ctl.res != RS_NONE) && flags.out_free;
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !rsp.ready);
        status_next    = status_reg;
        granted_next   = granted_reg;
        if (out_load)
        begin
            case (ctl.res)
                RS_OK:
                begin
                    status_next  = ST_DONE;
                    granted_next = INDEX_W'(base_reg);
                end
                RS_FAIL:
                begin
                    status_next  = ST_NOFIT;
                    granted_next = '0;
                end
                default:
                begin
                    status_next  = ST_DONE;
                    granted_next = '0;
                end
            endcase
        end
        clr_next = ctl.clr_inc ? clr_reg + AW'(1) : clr_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        base_reg    <= base_next;
        sz_reg      <= sz_next;
        used_reg    <= used_next;
        tot_reg     <= tot_next;
        need_reg    <= need_next;
        idx_reg     <= idx_next;
        rtype_reg   <= rtype_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    assign req.ready         = ctl.in_rdy;
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.granted_index = granted_reg;

endmodule

>>> rtl/boundary_tag_first_fit_allocator.sv
// Top level of the first-fit boundary-tag heap allocator.
//
//  Port  Role    Payload                                    Transaction
//  req   sink    req_type, request_bytes, block_index       valid && ready
//  rsp   source  status, granted_index                      valid && ready
//
// After its transaction, an allocation scans the blocks in address order. A
// successful one adds 2 tag writes, or 4 when it splits off a remainder. The
// microprogram makes at most one tag write and one tag read per step, so the
// scan loop sets the allocation time. After reset a clearing pass writes the
// store; no request is taken until it ends. A stalled response holds the
// sequencer at its result step, but the next request is taken while a response
// waits.
module boundary_tag_first_fit_allocator #(
    parameter int HEAP_WORDS = btff_pkg::HEAP_WORDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    btff_req_if.sink   req,
    btff_rsp_if.source rsp
);
    import btff_pkg::*;

    ctl_t   ctl;
    flags_t flags;

    // Microprogram sequencer
    btff_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    // Datapath with the tag store
    btff_dpath #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .flags (flags),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

>>> bench/tb_boundary_tag_first_fit_allocator.sv
// Self-checking testbench for the first-fit boundary-tag heap allocator.
`timescale 1ns / 1ps

module tb_boundary_tag_first_fit_allocator;
    import btff_pkg::*;

    localparam int unsigned HEAP       = HEAP_WORDS_DEF;
    localparam int          IDLE_LIMIT = 20000;
    localparam int          ITEMS      = 1600;
    localparam int          NOISE_FROM = 1500;
    localparam int          MAX_BYTES  = 16376;

    // One response transaction as the allocator should return it.
    typedef struct {
        logic               status;
        logic [INDEX_W-1:0] index;
    } grant_t;

    // Scoreboard: a word-level copy of the heap and the grants still awaited.
    class heap_scoreboard;
        logic [13:0] tag_store [HEAP];
        grant_t      awaited [$];
        int          errors;

        function new();
            errors = 0;
            foreach (tag_store[i])
                tag_store[i] = '0;
            write_block(0, HEAP, 1'b0);
        endfunction

        function int unsigned size_at(int unsigned at);
            return int'(tag_store[at][13:1]);
        endfunction

        function bit used_at(int unsigned at);
            return tag_store[at][0];
        endfunction

        // Header and footer carry the same tag; a one-word block shares them.
        function void write_block(int unsigned at, int unsigned len, bit used);
            logic [13:0] tag;
            tag = {len[12:0], used};
            tag_store[at] = tag;
            tag_store[at + len - 1] = tag;
        endfunction

        // Walk the blocks in address order and take the first free one that fits.
        function logic first_fit(logic [REQ_BYTES_W-1:0] bytes, output int unsigned where);
            int unsigned need;
            int unsigned p;
            int unsigned len;
            need  = ((int'(bytes) + 3) >> 2) + 2;
            p     = 0;
            where = 0;
            while (p < HEAP)
            begin
                len = size_at(p);
                if (len == 0 || len > HEAP - p)
                    return ST_NOFIT;
                if (!used_at(p) && len >= need)
                begin
                    write_block(p, need, 1'b1);
                    if (need < len)
                        write_block(p + need, len - need, 1'b0);
                    where = p;
                    return ST_DONE;
                end
                p += len;
            end
            return ST_NOFIT;
        endfunction

        // Clear the used bit, then coalesce with a free successor and predecessor.
        function void release_at(int unsigned ptr);
            int unsigned len;
            int unsigned succ;
            int unsigned pred;
            int unsigned plen;
            int unsigned total;
            if (ptr >= HEAP)
                return;
            len = size_at(ptr);
            if (len == 0 || len > HEAP - ptr)
                return;
            write_block(ptr, len, 1'b0);

            succ = ptr + len;
            if (succ < HEAP && !used_at(succ))
            begin
                total = len + size_at(succ);
                if (total <= HEAP - ptr)
                begin
                    write_block(ptr, total, 1'b0);
                    len = total;
                end
            end

            if (ptr != 0)
            begin
                plen = size_at(ptr - 1);
                if (plen != 0 && plen <= ptr)
                begin
                    pred = ptr - plen;
                    if (!used_at(pred))
                    begin
                        total = size_at(pred) + len;
                        if (total != 0 && total <= HEAP - pred)
                            write_block(pred, total, 1'b0);
                    end
                end
            end
        endfunction

        // Called for every accepted request transaction.
        function void note_request(logic kind, logic [REQ_BYTES_W-1:0] bytes,
                                   logic [INDEX_W-1:0] index, output grant_t g);
            int unsigned where;
            g.status = ST_DONE;
            g.index  = '0;
            if (kind == REQ_ALLOC)
            begin
                g.status = first_fit(bytes, where);
                if (g.status == ST_DONE)
                    g.index = where[INDEX_W-1:0];
            end
            else
                release_at(int'(index));
            awaited.push_back(g);
        endfunction

        // Called for every accepted response transaction.
        function void check_response(logic status, logic [INDEX_W-1:0] index);
            grant_t want;
            if (awaited.size() == 0)
            begin
                $error("response with no request waiting: status %0d, granted_index %0d",
                       status, index);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (index !== want.index)
            begin
                $error("granted_index: expected %0d, actual %0d", want.index, index);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    btff_req_if req_ch ();
    btff_rsp_if rsp_ch ();

    heap_scoreboard sb = new();

    // Headers of blocks currently held, and of blocks recently handed back.
    int unsigned held [$];
    int unsigned handed_back [$];
    bit          last_failed;
    bit          req_steady;
    bit          rsp_steady;
    int          idle_cycles;

    boundary_tag_first_fit_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Present one request, wait for its transaction and predict the outcome.
    task automatic transact(input logic kind, input logic [REQ_BYTES_W-1:0] bytes,
                            input logic [INDEX_W-1:0] index, output grant_t g);
        int gap;
        if ($urandom_range(0, 39) == 0)
            req_steady = !req_steady;
        gap = req_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.request_bytes <= bytes;
        req_ch.block_index   <= index;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(kind, bytes, index, g);
    endtask

    task automatic allocate(input int unsigned bytes);
        grant_t g;
        transact(REQ_ALLOC, bytes[REQ_BYTES_W-1:0],
                 INDEX_W'($urandom_range(0, HEAP - 1)), g);
        last_failed = (g.status == ST_NOFIT);
        if (g.status == ST_DONE)
            held.push_back(32'(g.index));
    endtask

    task automatic release_block(input int unsigned index);
        grant_t g;
        transact(REQ_FREE, REQ_BYTES_W'($urandom_range(0, MAX_BYTES)),
                 index[INDEX_W-1:0], g);
        last_failed = 1'b0;
        for (int i = held.size() - 1; i >= 0; i--)
            if (held[i] == index)
                held.delete(i);
        handed_back.push_back(index);
        if (handed_back.size() > 16)
            void'(handed_back.pop_front());
    endtask

    // Mostly small requests, with the occasional large one.
    function automatic int unsigned pick_bytes();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 64);
        if (r < 90)
            return $urandom_range(65, 1024);
        if (r < 98)
            return $urandom_range(1025, 4000);
        return $urandom_range(4001, MAX_BYTES);
    endfunction

    // Response side: random back-pressure with calm stretches.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rsp_steady = !rsp_steady;
            stall = rsp_steady ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
        end
    end

    // Response monitor.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_response(rsp_ch.status, rsp_ch.granted_index);
    end

    // Watchdog on cycles without any transaction; covers the clearing pass.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus and end of run.
    initial
    begin
        int unsigned r;
        idle_cycles          = 0;
        last_failed          = 1'b0;
        req_steady           = 1'b0;
        rsp_steady           = 1'b0;
        rst_n                = 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_ALLOC;
        req_ch.request_bytes <= '0;
        req_ch.block_index   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero-byte request, a request larger than the heap, exact fit,
        // a one-word remainder, coalescing on both sides, double free, frees of
        // words holding malformed tags, and a whole-heap grant.
        allocate(0);
        allocate(MAX_BYTES + 1);
        allocate(1);
        allocate(4);
        release_block(2);
        allocate(4);
        release_block(2);
        allocate(0);
        release_block(5);
        release_block(2);
        release_block(0);
        release_block(0);
        release_block(HEAP - 1);
        release_block(100);
        allocate(MAX_BYTES);
        allocate(0);
        release_block(0);
        allocate(MAX_BYTES - 4);
        release_block(0);
        allocate(MAX_BYTES - 3);
        release_block(0);

        // Random: well-formed allocate and free sequences, then a closing stretch that
        // mixes allocations with frees at arbitrary words and repeated frees.
        for (int n = 0; n < ITEMS; n++)
        begin
            if (n >= NOISE_FROM)
            begin
                r = $urandom_range(0, 9);
                if (r < 4)
                    allocate($urandom_range(0, MAX_BYTES));
                else if (r < 6 && held.size() > 0)
                    release_block(held[$urandom_range(0, held.size() - 1)]);
                else if (r >= 8 && handed_back.size() > 0)
                    release_block(handed_back[$urandom_range(0, handed_back.size() - 1)]);
                else
                    release_block($urandom_range(0, HEAP - 1));
            end
            else if (held.size() == 0 ||
                     (!last_failed && held.size() < 60 && $urandom_range(0, 99) < 55))
                allocate(pick_bytes());
            else
                release_block(held[$urandom_range(0, held.size() - 1)]);
        end
        req_ch.valid <= 1'b0;

        // Drain the outstanding grants, then allow for any stray response.
        while (sb.awaited.size() > 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
